// ===== hdl/bmm_pkg.sv =====
`timescale 1ns / 1ps
package bmm_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int ADDR_W = 5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [2*WORD_W-1:0] dword_t;

	typedef enum logic [1:0] {
		REG_MODULUS = 2'd0,
		REG_BFAC_HI = 2'd1,
		REG_BFAC_LO = 2'd2
	} reg_idx_t;

	typedef struct packed {
		word_t modulus;
		word_t bfac_hi;
		word_t bfac_lo;
	} cfg_t;

	// full product of the two operands
	typedef struct packed {
		word_t ph;
		word_t pl;
		logic  last;
	} prod_t;

	// quotient estimate with the low product word it applies to
	typedef struct packed {
		word_t q;
		word_t pl;
		logic  last;
	} quot_t;

	function automatic word_t mul32(input logic [HALF_W-1:0] a, input logic [HALF_W-1:0] b);
		return WORD_W'(a) * WORD_W'(b);
	endfunction

	// combine the four 32x32 partial products of a 64x64 multiply
	function automatic dword_t join_partials(input word_t p00, input word_t p01,
		input word_t p10, input word_t p11);
		logic [HALF_W+1:0] mid;
		word_t             hi;
		mid = {2'b00, p00[WORD_W-1:HALF_W]} + {2'b00, p01[HALF_W-1:0]}
			+ {2'b00, p10[HALF_W-1:0]};
		hi  = p11 + {{HALF_W{1'b0}}, p01[WORD_W-1:HALF_W]}
			+ {{HALF_W{1'b0}}, p10[WORD_W-1:HALF_W]}
			+ {{(WORD_W-2){1'b0}}, mid[HALF_W+1:HALF_W]};
		return {hi, mid[HALF_W-1:0], p00[HALF_W-1:0]};
	endfunction

endpackage

// ===== hdl/barrett_modular_multiplier.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: first_operand, second_operand; tlast: last_in
// m_*       out  m_tvalid/m_tready  tdata: product_mod; tlast: last_out
// apb       in   psel/penable       modulus, barrett factor high word, barrett factor low word
//
// one transfer per cycle in and out unless m_tready stalls a full pipeline; a result
// passes 9 stages (2 product, 4 quotient, 3 reduction, 32x32 multipliers registered)
// arst_n clears every stage valid and loads modulus 1, barrett words 0
// a stage holds while the one after it is full and stalled; empty stages still fill,
// so input keeps flowing while a result waits on m_tready
module barrett_modular_multiplier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [127:0]                s_tdata,   // first_operand, second_operand
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [63:0]                 m_tdata,   // product_mod
	output logic                        m_tlast,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bmm_pkg::ADDR_W-1:0]  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);
	import bmm_pkg::*;

	cfg_t  cfg;
	prod_t prod;
	quot_t quot;
	logic  prod_valid, prod_ready, quot_valid, quot_ready;

	bmm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmm_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.a         (s_tdata[63:0]),
		.b         (s_tdata[127:64]),
		.last      (s_tlast),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out       (prod)
	);

	bmm_quotient u_quotient (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (prod_valid),
		.in_ready   (prod_ready),
		.in         (prod),
		.bfac_hi    (cfg.bfac_hi),
		.bfac_lo    (cfg.bfac_lo),
		.out_valid  (quot_valid),
		.out_ready  (quot_ready),
		.out        (quot)
	);

	bmm_reduce u_reduce (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (quot_valid),
		.in_ready    (quot_ready),
		.in          (quot),
		.modulus     (cfg.modulus),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.product_mod (m_tdata),
		.last_out    (m_tlast)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && prod_valid && quot_valid)
		else $error("input stalled while the pipeline had room");

	a_output_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && quot_valid |=> m_tvalid)
		else $error("pending result dropped without a transfer");

endmodule

// ===== hdl/bmm_regs.sv =====
`timescale 1ns / 1ps
module bmm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmm_pkg::ADDR_W-1:0]   paddr,
	input  bmm_pkg::word_t               pwdata,
	output bmm_pkg::word_t               prdata,
	output logic                         pready,
	output bmm_pkg::cfg_t                cfg
);
	import bmm_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	word_t    modulus_q;
	word_t    bfac_hi_q;
	word_t    bfac_lo_q;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= word_t'(1);
			bfac_hi_q <= '0;
			bfac_lo_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_MODULUS: modulus_q <= pwdata;
				REG_BFAC_HI: bfac_hi_q <= pwdata;
				REG_BFAC_LO: bfac_lo_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODULUS: prdata = modulus_q;
			REG_BFAC_HI: prdata = bfac_hi_q;
			REG_BFAC_LO: prdata = bfac_lo_q;
			default:     prdata = '0;
		endcase
	end

	assign cfg.modulus = modulus_q;
	assign cfg.bfac_hi = bfac_hi_q;
	assign cfg.bfac_lo = bfac_lo_q;

	a_modulus_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && idx == REG_MODULUS |=> modulus_q == $past(pwdata))
		else $error("modulus register missed a write");

endmodule

// ===== hdl/bmm_product.sv =====
`timescale 1ns / 1ps
module bmm_product (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bmm_pkg::word_t  a,
	input  bmm_pkg::word_t  b,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_ready,
	output bmm_pkg::prod_t  out
);
	import bmm_pkg::*;

	logic  v_s1, v_s2, en_s1, en_s2;
	word_t p00_s1, p01_s1, p10_s1, p11_s1;
	logic  last_s1;
	prod_t prod_s2;
	dword_t full;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	assign full = join_partials(p00_s1, p01_s1, p10_s1, p11_s1);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p00_s1  <= mul32(a[HALF_W-1:0], b[HALF_W-1:0]);
			p01_s1  <= mul32(a[HALF_W-1:0], b[WORD_W-1:HALF_W]);
			p10_s1  <= mul32(a[WORD_W-1:HALF_W], b[HALF_W-1:0]);
			p11_s1  <= mul32(a[WORD_W-1:HALF_W], b[WORD_W-1:HALF_W]);
			last_s1 <= last;
		end
		if (en_s2) begin
			prod_s2.ph   <= full[2*WORD_W-1:WORD_W];
			prod_s2.pl   <= full[WORD_W-1:0];
			prod_s2.last <= last_s1;
		end
	end

	assign out_valid = v_s2;
	assign out       = prod_s2;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && !out_ready)
		else $error("product stage refused a transfer with room left");

endmodule

// ===== hdl/bmm_quotient.sv =====
`timescale 1ns / 1ps
module bmm_quotient (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bmm_pkg::prod_t  in,
	input  bmm_pkg::word_t  bfac_hi,
	input  bmm_pkg::word_t  bfac_lo,
	output logic            out_valid,
	input  logic            out_ready,
	output bmm_pkg::quot_t  out
);
	import bmm_pkg::*;

	logic  v_s1, v_s2, v_s3, v_s4;
	logic  en_s1, en_s2, en_s3, en_s4;

	// pl*blo, pl*bhi, ph*blo as partials; ph*bhi only its low word
	word_t xa_s1, xb_s1, xc_s1, xd_s1;
	word_t ya_s1, yb_s1, yc_s1, yd_s1;
	word_t za_s1, zb_s1, zc_s1, zd_s1;
	word_t wa_s1;
	logic [HALF_W-1:0] wb_s1, wc_s1;
	word_t pl_s1, pl_s2, pl_s3;
	logic  last_s1, last_s2, last_s3;

	word_t  x_s2, w_s2;
	dword_t y_s2, z_s2;
	word_t  shi_s3, w_s3;
	quot_t  quot_s4;

	dword_t x_full, col_sum;
	logic [HALF_W-1:0] w_mid;

	word_t ph, pl;
	assign ph = in.ph;
	assign pl = in.pl;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	assign x_full  = join_partials(xa_s1, xb_s1, xc_s1, xd_s1);
	assign w_mid   = wb_s1 + wc_s1;
	// only bits 64 and up of the middle column reach the quotient
	assign col_sum = {{WORD_W{1'b0}}, x_s2} + y_s2 + z_s2;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			xa_s1   <= mul32(pl[HALF_W-1:0], bfac_lo[HALF_W-1:0]);
			xb_s1   <= mul32(pl[HALF_W-1:0], bfac_lo[WORD_W-1:HALF_W]);
			xc_s1   <= mul32(pl[WORD_W-1:HALF_W], bfac_lo[HALF_W-1:0]);
			xd_s1   <= mul32(pl[WORD_W-1:HALF_W], bfac_lo[WORD_W-1:HALF_W]);
			ya_s1   <= mul32(pl[HALF_W-1:0], bfac_hi[HALF_W-1:0]);
			yb_s1   <= mul32(pl[HALF_W-1:0], bfac_hi[WORD_W-1:HALF_W]);
			yc_s1   <= mul32(pl[WORD_W-1:HALF_W], bfac_hi[HALF_W-1:0]);
			yd_s1   <= mul32(pl[WORD_W-1:HALF_W], bfac_hi[WORD_W-1:HALF_W]);
			za_s1   <= mul32(ph[HALF_W-1:0], bfac_lo[HALF_W-1:0]);
			zb_s1   <= mul32(ph[HALF_W-1:0], bfac_lo[WORD_W-1:HALF_W]);
			zc_s1   <= mul32(ph[WORD_W-1:HALF_W], bfac_lo[HALF_W-1:0]);
			zd_s1   <= mul32(ph[WORD_W-1:HALF_W], bfac_lo[WORD_W-1:HALF_W]);
			wa_s1   <= mul32(ph[HALF_W-1:0], bfac_hi[HALF_W-1:0]);
			wb_s1   <= HALF_W'(mul32(ph[HALF_W-1:0], bfac_hi[WORD_W-1:HALF_W]));
			wc_s1   <= HALF_W'(mul32(ph[WORD_W-1:HALF_W], bfac_hi[HALF_W-1:0]));
			pl_s1   <= pl;
			last_s1 <= in.last;
		end
		if (en_s2) begin
			x_s2    <= x_full[2*WORD_W-1:WORD_W];
			y_s2    <= join_partials(ya_s1, yb_s1, yc_s1, yd_s1);
			z_s2    <= join_partials(za_s1, zb_s1, zc_s1, zd_s1);
			w_s2    <= wa_s1 + {w_mid, {HALF_W{1'b0}}};
			pl_s2   <= pl_s1;
			last_s2 <= last_s1;
		end
		if (en_s3) begin
			shi_s3  <= col_sum[2*WORD_W-1:WORD_W];
			w_s3    <= w_s2;
			pl_s3   <= pl_s2;
			last_s3 <= last_s2;
		end
		if (en_s4) begin
			quot_s4.q    <= shi_s3 + w_s3;
			quot_s4.pl   <= pl_s3;
			quot_s4.last <= last_s3;
		end
	end

	assign out_valid = v_s4;
	assign out       = quot_s4;

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en_s3 |=> v_s2 && $stable(y_s2) && $stable(z_s2) && $stable(pl_s2))
		else $error("stalled column stage lost its contents");

endmodule

// ===== hdl/bmm_reduce.sv =====
`timescale 1ns / 1ps
module bmm_reduce (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bmm_pkg::quot_t  in,
	input  bmm_pkg::word_t  modulus,
	output logic            out_valid,
	input  logic            out_ready,
	output bmm_pkg::word_t  product_mod,
	output logic            last_out
);
	import bmm_pkg::*;

	logic  v_s1, v_s2, v_s3;
	logic  en_s1, en_s2, en_s3;
	word_t m00_s1;
	logic [HALF_W-1:0] m01_s1, m10_s1;
	word_t pl_s1, r_s2, res_s3;
	logic  last_s1, last_s2, last_s3;
	logic [HALF_W-1:0] m_mid;
	word_t q;

	assign q = in.q;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	assign m_mid = m01_s1 + m10_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			// low word of q*modulus
			m00_s1  <= mul32(q[HALF_W-1:0], modulus[HALF_W-1:0]);
			m01_s1  <= HALF_W'(mul32(q[HALF_W-1:0], modulus[WORD_W-1:HALF_W]));
			m10_s1  <= HALF_W'(mul32(q[WORD_W-1:HALF_W], modulus[HALF_W-1:0]));
			pl_s1   <= in.pl;
			last_s1 <= in.last;
		end
		if (en_s2) begin
			r_s2    <= pl_s1 - m00_s1 - {m_mid, {HALF_W{1'b0}}};
			last_s2 <= last_s1;
		end
		if (en_s3) begin
			res_s3  <= (r_s2 >= modulus) ? r_s2 - modulus : r_s2;
			last_s3 <= last_s2;
		end
	end

	assign out_valid   = v_s3;
	assign product_mod = res_s3;
	assign last_out    = last_s3;

endmodule

// ===== test/barrett_modular_multiplier_tb.sv =====
`timescale 1ns / 1ps
module barrett_modular_multiplier_tb;
	import bmm_pkg::*;

	typedef struct packed {
		word_t value;
		logic  last;
	} modprod_t;

	class modmul_board;
		cfg_t     cfg;
		modprod_t pending_products[$];
		int       errors;

		function new();
			cfg.modulus = 64'd1;
			cfg.bfac_hi = '0;
			cfg.bfac_lo = '0;
			errors      = 0;
		endfunction

		function void set_reg(input reg_idx_t idx, input word_t value);
			case (idx)
				REG_MODULUS: begin
					cfg.modulus = value;
				end
				REG_BFAC_HI: begin
					cfg.bfac_hi = value;
				end
				REG_BFAC_LO: begin
					cfg.bfac_lo = value;
				end
				default: begin
				end
			endcase
		endfunction

		// quotient is bits 191:128 of the full product times the barrett factor
		function word_t reduce_product(input word_t a, input word_t b);
			dword_t       prod;
			logic [255:0] wide;
			word_t        q;
			word_t        r;
			prod = {64'b0, a} * {64'b0, b};
			wide = {128'b0, prod} * {128'b0, cfg.bfac_hi, cfg.bfac_lo};
			q    = wide[191:128];
			r    = prod[63:0] - q * cfg.modulus;
			if (r >= cfg.modulus) begin
				r = r - cfg.modulus;
			end
			return r;
		endfunction

		function void note_operands(input word_t a, input word_t b, input logic last);
			modprod_t want;
			want.value = reduce_product(a, b);
			want.last  = last;
			pending_products.push_back(want);
		endfunction

		function void check_product(input word_t value, input logic last);
			modprod_t want;
			if (pending_products.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result %h last %b", value, last);
				end
				return;
			end
			want = pending_products.pop_front();
			if (want.value !== value || want.last !== last) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected %h last %b, got %h last %b",
						want.value, want.last, value, last);
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [127:0]        s_tdata;   // first_operand, second_operand
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [63:0]         m_tdata;   // product_mod
	logic                m_tlast;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [63:0]         pwdata;
	logic [63:0]         prdata;
	logic                pready;

	modmul_board sb;
	int          src_idle   = 0;
	int          sink_stall = 0;

	barrett_modular_multiplier i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall);
	end

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			sb.check_product(m_tdata, m_tlast);
		end
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [127:0] barrett_factor(input word_t m);
		logic [128:0] quot;
		quot = (129'd1 << 128) / {65'b0, m};
		return quot[127:0];
	endfunction

	// mostly operands below the modulus, plus extremes and unreduced ones
	function automatic word_t pick_operand();
		word_t m;
		m = sb.cfg.modulus;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return (m == 0) ? rand_word() : m - 64'd1;
			3, 4, 5, 6: return (m == 0) ? rand_word() : rand_word() % m;
			default: return rand_word();
		endcase
	endfunction

	// ends idle, with psel low across a clock edge, so back-to-back writes never lower and raise psel in one step
	task automatic write_reg(input reg_idx_t idx, input word_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(input word_t modulus, input word_t bhi, input word_t blo);
		while (sb.pending_products.size() != 0) begin
			@(posedge clk);
		end
		write_reg(REG_MODULUS, modulus);
		write_reg(REG_BFAC_HI, bhi);
		write_reg(REG_BFAC_LO, blo);
	endtask

	task automatic use_modulus(input word_t m);
		logic [127:0] factor;
		factor = barrett_factor(m);
		configure(m, factor[127:64], factor[63:0]);
	endtask

	task automatic send_item(input word_t a, input word_t b, input logic last);
		if (src_idle != 0 && $urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tlast  <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_operands(a, b, last);
	endtask

	task automatic run_phase(input int count);
		word_t a;
		word_t b;
		for (int i = 0; i < count; i++) begin
			a = pick_operand();
			b = pick_operand();
			send_item(a, b, $urandom_range(7) == 0);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		word_t m;
		sb = new();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: modulus one, barrett factor zero
		send_item('0, '0, 1'b0);
		send_item('1, '1, 1'b1);
		send_item(64'd1, 64'd1, 1'b0);
		s_tvalid <= 1'b0;

		// largest 64-bit prime with its proper factor
		m = 64'hFFFF_FFFF_FFFF_FFC5;
		use_modulus(m);
		send_item('0, '0, 1'b1);
		send_item(64'd1, 64'd1, 1'b0);
		send_item(m - 64'd1, m - 64'd1, 1'b1);
		send_item(m - 64'd1, 64'd1, 1'b0);
		send_item('1, '1, 1'b1);
		send_item('1, '0, 1'b0);
		send_item(m, m, 1'b1);
		send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
		s_tvalid <= 1'b0;

		// zero modulus passes the low product word
		configure('0, rand_word(), rand_word());
		send_item('1, '1, 1'b1);
		send_item(64'h1234_5678_9ABC_DEF0, 64'hDEAD_BEEF_CAFE_F00D, 1'b0);
		send_item(64'd1, '1, 1'b1);
		s_tvalid <= 1'b0;

		// factor far too large for the modulus
		configure(64'd3, '1, '1);
		send_item('1, '1, 1'b0);
		send_item(64'd2, 64'd2, 1'b1);
		send_item(64'd5, 64'd7, 1'b0);
		s_tvalid <= 1'b0;

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: use_modulus(rand_word() | {1'b1, 63'b0});
				1: use_modulus('1);
				2: use_modulus(word_t'($urandom_range(1000, 2)));
				3: use_modulus(64'd1);
				4: use_modulus((rand_word() >> 31) | 64'd1);
				5: configure('0, rand_word(), rand_word());
				6: configure(rand_word(), '1, '1);
				default: use_modulus((rand_word() >> $urandom_range(62)) | 64'd1);
			endcase
			case (p % 4)
				0: begin
					src_idle   = 0;
					sink_stall = 0;
				end
				1: begin
					src_idle   = 79;
					sink_stall = 0;
				end
				2: begin
					src_idle   = 0;
					sink_stall = 79;
				end
				default: begin
					src_idle   = 9;
					sink_stall = 9;
				end
			endcase
			run_phase(136);
		end

		while (sb.pending_products.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bmm_pkg.sv
hdl/bmm_regs.sv
hdl/bmm_product.sv
hdl/bmm_quotient.sv
hdl/bmm_reduce.sv
hdl/barrett_modular_multiplier.sv
test/barrett_modular_multiplier_tb.sv
